// ----- design/assert_macros.svh -----
// assertion macros used by the checker file

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define SUID_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("suid: same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define SUID_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("suid: next-cycle check failed");

`endif

// ----- design/suid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suid_pkg
// Shared widths, item kind codes and sequencer states for the set core.
// ----------------------------------------------------------------------------
package suid_pkg;

    localparam int ELEM_W           = 8;
    localparam int KIND_W           = 3;
    localparam int MAX_ELEMENTS_DEF = 16;
    localparam int MAX_RESULTS      = 32;
    localparam int RES_CW           = $clog2(MAX_RESULTS + 1);

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [ELEM_W-1:0] elem_t;

    // item kinds
    localparam kind_t KIND_CLEAR  = 3'd0;
    localparam kind_t KIND_LOAD_A = 3'd1;
    localparam kind_t KIND_LOAD_B = 3'd2;
    localparam kind_t KIND_UNION  = 3'd3;
    localparam kind_t KIND_INTER  = 3'd4;
    localparam kind_t KIND_DIFF   = 3'd5;

    // query sequencer states
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_OREAD  = 6'b000010,
        ST_IREAD  = 6'b000100,
        ST_CMP    = 6'b001000,
        ST_TAKE   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

endpackage

// ----- design/set_union_intersection_difference_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_union_intersection_difference_core
// Two small element stores A and B with union, intersection and difference
// queries walked by one shared comparator under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start / busy            kind, element
//  result    result_valid (strobe)   element_res, is_empty, is_last, overflow
//
//  clear and load items complete while busy stays low.
//  a query holds busy high while it walks the stores: per outer element a
//  read state (ST_OREAD), per inner compare a read and a compare state
//  (ST_IREAD, ST_CMP; one store read port, one comparator), ST_IREAD to end
//  an unmatched inner walk and ST_TAKE to keep it; ST_OREAD closes each
//  pass and ST_FINISH finishes the query.
//  each kept element is held back until the next one is kept or the query
//  finishes; the last result shows in the first cycle with busy low.
//  reset clears counts and flags, not store contents.
//  the receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module set_union_intersection_difference_core #(
    parameter int MAX_ELEMENTS = suid_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  suid_pkg::kind_t      kind,
    input  suid_pkg::elem_t      element,
    output logic                 result_valid,
    output suid_pkg::elem_t      element_res,
    output logic                 is_empty,
    output logic                 is_last,
    output logic                 overflow
);
    import suid_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    // element stores
    elem_t mem_a [MAX_ELEMENTS];
    elem_t mem_b [MAX_ELEMENTS];
    elem_t a_rd_reg;
    elem_t b_rd_reg;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_a_reg, count_a_next;
    logic [CW-1:0]   count_b_reg, count_b_next;
    logic            ovf_reg, ovf_next;
    kind_t           op_reg, op_next;
    logic            second_reg, second_next;
    logic [CW-1:0]   oi_reg, oi_next;
    logic [CW-1:0]   ij_reg, ij_next;
    logic [RES_CW-1:0] n_reg, n_next;
    elem_t           pend_reg, pend_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            rv_reg, rv_next;
    elem_t           res_reg, res_next;
    logic            empty_reg, empty_next;
    logic            last_reg, last_next;
    logic            res_ovf_reg, res_ovf_next;

    logic            accept;
    logic            a_we, b_we;
    logic [IW-1:0]   a_addr, b_addr;
    logic            outer_is_b;
    logic            pass_all;
    logic            want_found;
    logic [CW-1:0]   ocnt, icnt;
    elem_t           outer_val, inner_val;
    logic            hit;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign outer_is_b = (op_reg == KIND_UNION) && second_reg;
    assign pass_all   = (op_reg == KIND_UNION) && !second_reg;
    assign want_found = (op_reg == KIND_INTER);
    assign ocnt       = outer_is_b ? count_b_reg : count_a_reg;
    assign icnt       = outer_is_b ? count_a_reg : count_b_reg;
    assign outer_val  = outer_is_b ? b_rd_reg : a_rd_reg;
    assign inner_val  = outer_is_b ? a_rd_reg : b_rd_reg;

    // the shared comparator
    assign hit = (outer_val == inner_val);

    // load strobes
    assign a_we = accept && (kind == KIND_LOAD_A) && (count_a_reg < CW'(MAX_ELEMENTS));
    assign b_we = accept && (kind == KIND_LOAD_B) && (count_b_reg < CW'(MAX_ELEMENTS));

    // addresses: the fill count while loading, else outer index on the outer store, inner index on the other
    always_comb
    begin
        if (a_we) begin
            a_addr = count_a_reg[IW-1:0];
        end else if (outer_is_b) begin
            a_addr = ij_reg[IW-1:0];
        end else begin
            a_addr = oi_reg[IW-1:0];
        end
        if (b_we) begin
            b_addr = count_b_reg[IW-1:0];
        end else if (outer_is_b) begin
            b_addr = oi_reg[IW-1:0];
        end else begin
            b_addr = ij_reg[IW-1:0];
        end
    end

    // store A
    always_ff @(posedge clk)
    begin
        if (a_we) begin
            mem_a[a_addr] <= element;
        end
        a_rd_reg <= mem_a[a_addr];
    end

    // store B
    always_ff @(posedge clk)
    begin
        if (b_we) begin
            mem_b[b_addr] <= element;
        end
        b_rd_reg <= mem_b[b_addr];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        ovf_next        = ovf_reg;
        op_next         = op_reg;
        second_next     = second_reg;
        oi_next         = oi_reg;
        ij_next         = ij_reg;
        n_next          = n_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rv_next         = 1'b0;
        res_next        = res_reg;
        empty_next      = empty_reg;
        last_next       = last_reg;
        res_ovf_next    = res_ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    case (kind)
                        KIND_CLEAR:
                        begin
                            count_a_next = '0;
                            count_b_next = '0;
                            ovf_next     = 1'b0;
                        end
                        KIND_LOAD_A:
                        begin
                            if (a_we) begin
                                count_a_next = count_a_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_LOAD_B:
                        begin
                            if (b_we) begin
                                count_b_next = count_b_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_UNION, KIND_INTER, KIND_DIFF:
                        begin
                            op_next         = kind;
                            second_next     = 1'b0;
                            oi_next         = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_OREAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_OREAD:
            begin
                if (oi_reg >= ocnt) begin
                    if (pass_all) begin
                        // union moves on to the elements of B
                        second_next = 1'b1;
                        oi_next     = '0;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else if (pass_all) begin
                    state_next = ST_TAKE;
                end else begin
                    ij_next    = '0;
                    state_next = ST_IREAD;
                end
            end

            ST_IREAD:
            begin
                if (ij_reg >= icnt) begin
                    // not found in the inner store
                    if (!want_found) begin
                        state_next = ST_TAKE;
                    end else begin
                        oi_next    = oi_reg + 1'b1;
                        state_next = ST_OREAD;
                    end
                end else begin
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (hit) begin
                    if (want_found) begin
                        state_next = ST_TAKE;
                    end else begin
                        oi_next    = oi_reg + 1'b1;
                        state_next = ST_OREAD;
                    end
                end else begin
                    ij_next    = ij_reg + 1'b1;
                    state_next = ST_IREAD;
                end
            end

            ST_TAKE:
            begin
                // the held element goes out, the new one is held back
                if (pend_valid_reg) begin
                    rv_next      = 1'b1;
                    res_next     = pend_reg;
                    empty_next   = 1'b0;
                    last_next    = 1'b0;
                    res_ovf_next = ovf_reg;
                end
                pend_next       = outer_val;
                pend_valid_next = 1'b1;
                n_next          = n_reg + 1'b1;
                oi_next         = oi_reg + 1'b1;
                if (n_reg == RES_CW'(MAX_RESULTS - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_OREAD;
                end
            end

            ST_FINISH:
            begin
                rv_next      = 1'b1;
                res_next     = pend_valid_reg ? pend_reg : '0;
                empty_next   = !pend_valid_reg;
                last_next    = 1'b1;
                res_ovf_next = ovf_reg;
                pend_valid_next = 1'b0;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            rv_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            rv_reg         <= rv_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        second_reg  <= second_next;
        oi_reg      <= oi_next;
        ij_reg      <= ij_next;
        n_reg       <= n_next;
        pend_reg    <= pend_next;
        res_reg     <= res_next;
        empty_reg   <= empty_next;
        last_reg    <= last_next;
        res_ovf_reg <= res_ovf_next;
    end

    assign result_valid = rv_reg;
    assign element_res  = res_reg;
    assign is_empty     = empty_reg;
    assign is_last      = last_reg;
    assign overflow     = res_ovf_reg;

endmodule

// ----- design/suid_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suid_checker
// Port-level checks on the set core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module suid_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  suid_pkg::kind_t      kind,
    input  suid_pkg::elem_t      element,
    input  logic                 result_valid,
    input  suid_pkg::elem_t      element_res,
    input  logic                 is_empty,
    input  logic                 is_last,
    input  logic                 overflow
);
    import suid_pkg::*;

    logic take_simple;
    logic take_query;

    assign take_simple = start && !busy && (element == element || 1'b1) &&
                         (kind == KIND_CLEAR || kind == KIND_LOAD_A || kind == KIND_LOAD_B);
    assign take_query  = start && !busy &&
                         (kind == KIND_UNION || kind == KIND_INTER || kind == KIND_DIFF);

    // an empty answer is a single zero item that closes the query
    `SUID_ASSERT_IMPL(a_empty_is_last, clk, rst_n, result_valid && is_empty, is_last && element_res == '0)

    // clear and load leave the block idle with no result in the next cycle
    `SUID_ASSERT_NEXT(a_simple_one_cycle, clk, rst_n, take_simple, !busy && !result_valid)

    // a query keeps the block busy
    `SUID_ASSERT_NEXT(a_query_busy, clk, rst_n, take_query, busy)

    // a result seen while idle is the closing one of a query just ended
    `SUID_ASSERT_IMPL(a_idle_result_last, clk, rst_n, result_valid && !busy, $past(busy) && is_last)

    // overflow flag holds steady across the items of one query
    `SUID_ASSERT_IMPL(a_ovf_steady, clk, rst_n, result_valid && $past(result_valid), overflow == $past(overflow))

endmodule

bind set_union_intersection_difference_core suid_checker u_suid_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .element      (element),
    .result_valid (result_valid),
    .element_res  (element_res),
    .is_empty     (is_empty),
    .is_last      (is_last),
    .overflow     (overflow)
);

// ----- bench/set_union_intersection_difference_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_union_intersection_difference_core_tb
// Drives clear, load and query items into the set core through the start /
// busy handshake. A small table of directed items comes first, then random
// load-and-query sequences with some noise. Each item is run through a local
// copy of both sets as it is accepted, and every strobed result is checked
// field by field against the oldest predicted answer.
// ----------------------------------------------------------------------------
module set_union_intersection_difference_core_tb;
    import suid_pkg::*;

    localparam int SET_DEPTH    = MAX_ELEMENTS_DEF;
    localparam int NUM_ITEMS    = 350;
    localparam int NUM_DIRECTED = 20;

    // unused kind codes, the core ignores them
    localparam kind_t KIND_SPARE6 = 3'd6;
    localparam kind_t KIND_SPARE7 = 3'd7;

    typedef struct packed {
        elem_t value;
        logic  empty;
        logic  last;
        logic  ovf;
    } answer_t;

    typedef struct packed {
        kind_t   kind;
        elem_t   value;
        logic    typed;
        answer_t answer;
    } dir_row_t;

    localparam answer_t NO_ANSWER   = '0;
    localparam answer_t EMPTY_CLEAN = '{8'h00, 1'b1, 1'b1, 1'b0};

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    kind_t kind;
    elem_t element;
    logic  result_valid;
    elem_t element_res;
    logic  is_empty;
    logic  is_last;
    logic  overflow;

    // typed expectation that travels with the item on the same edge
    logic    hand_typed;
    answer_t hand_answer;

    // local copy of both sets
    elem_t a_vals [SET_DEPTH];
    elem_t b_vals [SET_DEPTH];
    int    a_fill;
    int    b_fill;
    logic  dropped_load;

    answer_t  answers_due [$];
    int       fail_count;
    int       items_sent;
    int       idle_pct;
    dir_row_t directed_rows [NUM_DIRECTED];

    set_union_intersection_difference_core #(
        .MAX_ELEMENTS (SET_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .element      (element),
        .result_valid (result_valid),
        .element_res  (element_res),
        .is_empty     (is_empty),
        .is_last      (is_last),
        .overflow     (overflow)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // membership of one value among the first fill entries
    function automatic logic holds(input elem_t vals [SET_DEPTH], input int fill,
                                   input elem_t v);
        for (int i = 0; i < fill; i++)
        begin
            if (vals[i] == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // update the set copy and, for queries, queue the answer items
    task automatic apply_item(input kind_t k, input elem_t v, input logic keep);
        elem_t found [$];
        logic  is_query;
        is_query = (k == KIND_UNION || k == KIND_INTER || k == KIND_DIFF);
        case (k)
            KIND_CLEAR:
            begin
                a_fill       = 0;
                b_fill       = 0;
                dropped_load = 1'b0;
            end
            KIND_LOAD_A:
            begin
                if (a_fill < SET_DEPTH)
                begin
                    a_vals[a_fill] = v;
                    a_fill++;
                end
                else
                    dropped_load = 1'b1;
            end
            KIND_LOAD_B:
            begin
                if (b_fill < SET_DEPTH)
                begin
                    b_vals[b_fill] = v;
                    b_fill++;
                end
                else
                    dropped_load = 1'b1;
            end
            KIND_UNION:
            begin
                for (int i = 0; i < a_fill; i++)
                    found.push_back(a_vals[i]);
                for (int i = 0; i < b_fill; i++)
                begin
                    if (!holds(a_vals, a_fill, b_vals[i]))
                        found.push_back(b_vals[i]);
                end
            end
            KIND_INTER:
            begin
                for (int i = 0; i < a_fill; i++)
                begin
                    if (holds(b_vals, b_fill, a_vals[i]))
                        found.push_back(a_vals[i]);
                end
            end
            KIND_DIFF:
            begin
                for (int i = 0; i < a_fill; i++)
                begin
                    if (!holds(b_vals, b_fill, a_vals[i]))
                        found.push_back(a_vals[i]);
                end
            end
            default:
            begin
            end
        endcase
        if (keep && is_query)
        begin
            // long answers are cut at the result limit
            while (found.size() > MAX_RESULTS)
                void'(found.pop_back());
            if (found.size() == 0)
                answers_due.push_back('{8'h00, 1'b1, 1'b1, dropped_load});
            else
                foreach (found[i])
                    answers_due.push_back('{found[i], 1'b0, i == found.size() - 1,
                                            dropped_load});
        end
    endtask

    // compare one strobed result with the oldest expected answer
    task automatic check_result();
        answer_t want;
        if (answers_due.size() == 0)
        begin
            $error("unexpected result item: element_res %0h", element_res);
            fail_count++;
        end
        else
        begin
            want = answers_due.pop_front();
            if (element_res !== want.value)
            begin
                $error("element_res expected %0h got %0h", want.value, element_res);
                fail_count++;
            end
            if (is_empty !== want.empty)
            begin
                $error("is_empty expected %0b got %0b", want.empty, is_empty);
                fail_count++;
            end
            if (is_last !== want.last)
            begin
                $error("is_last expected %0b got %0b", want.last, is_last);
                fail_count++;
            end
            if (overflow !== want.ovf)
            begin
                $error("overflow expected %0b got %0b", want.ovf, overflow);
                fail_count++;
            end
        end
    endtask

    // results are checked before a new item on the same edge is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                check_result();
            if (start && !busy)
            begin
                apply_item(kind, element, !hand_typed);
                if (hand_typed)
                    answers_due.push_back(hand_answer);
            end
        end
    end

    // present one item, hold it until accepted, then maybe idle
    task automatic send_item(input kind_t k, input elem_t v, input logic typed,
                             input answer_t ans);
        int gap;
        start       <= 1'b1;
        kind        <= k;
        element     <= v;
        hand_typed  <= typed;
        hand_answer <= ans;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (k <= KIND_DIFF)
            items_sent++;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every predicted result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    // set sizes: mostly small, now and then near or just past the store depth
    function automatic int pick_size();
        if ($urandom_range(9) == 0)
            return $urandom_range(SET_DEPTH - 4, SET_DEPTH + 2);
        return $urandom_range(0, 6);
    endfunction

    // element value; full sequences keep A even and B odd so they never meet
    function automatic elem_t pick_value(input int pool, input logic full,
                                         input logic odd);
        elem_t v;
        v = elem_t'($urandom_range(0, pool));
        if (full)
            v[0] = odd;
        return v;
    endfunction

    // one load-and-query sequence, or a burst of noise
    task automatic run_sequence(input logic full);
        int shape;
        int na;
        int nb;
        int pool;
        shape = $urandom_range(99);
        if (!full && shape < 12)
        begin
            repeat ($urandom_range(1, 6))
                send_item(kind_t'($urandom_range(0, 7)), elem_t'($urandom_range(0, 255)),
                          1'b0, NO_ANSWER);
        end
        else
        begin
            if (full || $urandom_range(3) != 0)
                send_item(KIND_CLEAR, elem_t'($urandom_range(0, 255)), 1'b0, NO_ANSWER);
            na   = full ? SET_DEPTH + $urandom_range(0, 2) : pick_size();
            nb   = full ? SET_DEPTH + $urandom_range(0, 2) : pick_size();
            pool = (full || $urandom_range(1)) ? 255 : 7;
            // loads of A and B interleaved at random
            while (na > 0 || nb > 0)
            begin
                if (nb == 0 || (na > 0 && $urandom_range(1) == 1))
                begin
                    send_item(KIND_LOAD_A, pick_value(pool, full, 1'b0), 1'b0, NO_ANSWER);
                    na--;
                end
                else
                begin
                    send_item(KIND_LOAD_B, pick_value(pool, full, 1'b1), 1'b0, NO_ANSWER);
                    nb--;
                end
            end
            repeat ($urandom_range(1, 3))
                send_item(kind_t'($urandom_range(KIND_UNION, KIND_DIFF)),
                          elem_t'($urandom_range(0, 255)), 1'b0, NO_ANSWER);
        end
    endtask

    // main stimulus
    initial
    begin
        int random_base;
        int target;
        fail_count   = 0;
        items_sent   = 0;
        idle_pct     = 0;
        a_fill       = 0;
        b_fill       = 0;
        dropped_load = 1'b0;
        foreach (a_vals[i])
        begin
            a_vals[i] = '0;
            b_vals[i] = '0;
        end
        rst_n       <= 1'b0;
        start       <= 1'b0;
        kind        <= KIND_CLEAR;
        element     <= '0;
        hand_typed  <= 1'b0;
        hand_answer <= NO_ANSWER;

        directed_rows = '{
            '{KIND_UNION,  8'h00, 1'b1, EMPTY_CLEAN},
            '{KIND_INTER,  8'hFF, 1'b1, EMPTY_CLEAN},
            '{KIND_DIFF,   8'h5A, 1'b1, EMPTY_CLEAN},
            '{KIND_LOAD_A, 8'h00, 1'b0, NO_ANSWER},
            '{KIND_LOAD_A, 8'hFF, 1'b0, NO_ANSWER},
            '{KIND_LOAD_A, 8'h55, 1'b0, NO_ANSWER},
            '{KIND_LOAD_B, 8'hFF, 1'b0, NO_ANSWER},
            '{KIND_LOAD_B, 8'hAA, 1'b0, NO_ANSWER},
            '{KIND_UNION,  8'h00, 1'b0, NO_ANSWER},
            '{KIND_INTER,  8'h00, 1'b1, '{8'hFF, 1'b0, 1'b1, 1'b0}},
            '{KIND_DIFF,   8'hFF, 1'b0, NO_ANSWER},
            '{KIND_SPARE6, 8'hFF, 1'b0, NO_ANSWER},
            '{KIND_SPARE7, 8'h00, 1'b0, NO_ANSWER},
            '{KIND_UNION,  8'hA5, 1'b0, NO_ANSWER},
            '{KIND_CLEAR,  8'h00, 1'b0, NO_ANSWER},
            '{KIND_DIFF,   8'h00, 1'b1, EMPTY_CLEAN},
            '{KIND_LOAD_B, 8'h01, 1'b0, NO_ANSWER},
            '{KIND_INTER,  8'h00, 1'b1, EMPTY_CLEAN},
            '{KIND_UNION,  8'h00, 1'b1, '{8'h01, 1'b0, 1'b1, 1'b0}},
            '{KIND_CLEAR,  8'hFF, 1'b0, NO_ANSWER}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, back to back
        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].answer);
        drain();

        // random phases, each ends by waiting for all results
        random_base = items_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       idle_pct = 0;
                1:       idle_pct = 70;
                2:       idle_pct = 0;
                default: idle_pct = 18;
            endcase
            target = random_base + NUM_ITEMS * (phase + 1) / 4;
            if (phase == 0)
                run_sequence(1'b1);
            while (items_sent < target)
                run_sequence(1'b0);
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("set_union_intersection_difference_core verification clean");
        else
            $display("set_union_intersection_difference_core verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("set_union_intersection_difference_core verification failed");
        $finish;
    end

endmodule
